// File: hdl/ffba_pkg.sv
// ffba_pkg: shared types and constants for the first-fit block allocator
// used by ffba_span_ram and first_fit_block_allocator; no dependencies
`timescale 1ns / 1ps

package ffba_pkg;

    localparam int ADDR_BITS  = 24;
    localparam int LIMIT_BITS = 25;
    localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = 25'h100_0000;

    // request codes
    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_FREE   = 2'd1;
    localparam logic [1:0] MODE_RESIZE = 2'd2;

    // result codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ARENA_FULL = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOC  = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]           mode;
        logic [ADDR_BITS-1:0] request_size;
        logic [ADDR_BITS-1:0] block_address;
    } t_in;

    typedef struct packed {
        logic [ADDR_BITS-1:0] granted_address;
        logic [ADDR_BITS-1:0] block_bytes;
        logic [1:0]           status;
    } t_out;

    // one table or hole entry
    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] size;
    } t_span;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE_RD,
        S_FREE_CMP,
        S_HOLE_WR,
        S_LSH_RD,
        S_LSH_WR,
        S_ALLOC_START,
        S_HOLE_RD,
        S_HOLE_CMP,
        S_HSH_RD,
        S_HSH_WR,
        S_LIVE_WR,
        S_DONE
    } t_state;

endpackage

// File: hdl/first_fit_block_allocator.sv
// first_fit_block_allocator: first-fit allocator over a byte arena of offsets
// depends on ffba_pkg and ffba_span_ram (live table and hole list)
//
//  channel  direction  handshake           payload
//  in       slave      i_in_valid/o_in_stall   ffba_pkg::t_in
//  out      master     o_out_valid/i_out_stall ffba_pkg::t_out
//  cfg      slave      i_cfg_valid/o_cfg_ready arena_limit, 25 bits
//
// one request at a time; a sequencer walks the live table and the hole list
// through their single read ports, a read state and then a compare state for
// each entry visited and a read state and a write state for each entry moved;
// a gap is closed from where the scan stopped. reset is synchronous and needs
// no clearing pass. the result waits in an output register; a stalled output
// holds the block in its final state until the transfer goes through.
`timescale 1ns / 1ps

module first_fit_block_allocator #(
    parameter int LIVE_SLOTS = 256,
    parameter int HOLE_SLOTS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ffba_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ffba_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ffba_pkg::LIMIT_BITS-1:0] i_cfg_data
);
    import ffba_pkg::*;

    localparam int LW  = $clog2(LIVE_SLOTS);
    localparam int LCW = $clog2(LIVE_SLOTS + 1);
    localparam int HW  = $clog2(HOLE_SLOTS);
    localparam int HCW = $clog2(HOLE_SLOTS + 1);
    localparam logic [LCW-1:0] LIVE_FULL = LCW'(LIVE_SLOTS);
    localparam logic [HCW-1:0] HOLE_FULL = HCW'(HOLE_SLOTS);

    t_state                 r_state, n_state;
    logic [1:0]             r_mode, n_mode;
    logic [ADDR_BITS-1:0]   r_req, n_req;
    logic [ADDR_BITS-1:0]   r_baddr, n_baddr;
    logic [ADDR_BITS-1:0]   r_bytes, n_bytes;
    logic [ADDR_BITS-1:0]   r_ga, n_ga;
    logic [1:0]             r_st, n_st;
    logic [ADDR_BITS-1:0]   r_hit, n_hit;
    logic [LCW-1:0]         r_lidx, n_lidx;
    logic [HCW-1:0]         r_hidx, n_hidx;
    logic [LIMIT_BITS-1:0]  r_limit, n_limit;
    logic [LIMIT_BITS-1:0]  r_tail, n_tail;
    logic [LCW-1:0]         r_live_cnt, n_live_cnt;
    logic [HCW-1:0]         r_hole_cnt, n_hole_cnt;
    logic [ADDR_BITS-1:0]   r_last, n_last;
    logic                   r_out_valid, n_out_valid;
    t_out                   r_out, n_out;

    logic                   in_xfer, out_free;
    logic [LCW-1:0]         lidx_next;
    logic [HCW-1:0]         hidx_next;
    logic [LIMIT_BITS-1:0]  tail_sum;
    logic                   live_hit, hole_fit, live_full;

    logic                   live_we, hole_we;
    logic [LW-1:0]          live_waddr, live_raddr;
    logic [HW-1:0]          hole_waddr, hole_raddr;
    t_span                  live_wdata, hole_wdata, live_q, hole_q;

    ffba_span_ram #(.DEPTH(LIVE_SLOTS)) u_live (
        .i_clk   (i_clk),
        .i_we    (live_we),
        .i_waddr (live_waddr),
        .i_wdata (live_wdata),
        .i_raddr (live_raddr),
        .o_rdata (live_q)
    );

    ffba_span_ram #(.DEPTH(HOLE_SLOTS)) u_hole (
        .i_clk   (i_clk),
        .i_we    (hole_we),
        .i_waddr (hole_waddr),
        .i_wdata (hole_wdata),
        .i_raddr (hole_raddr),
        .o_rdata (hole_q)
    );

    // handshakes and shared compare/add unit
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;
    assign lidx_next   = r_lidx + 1'b1;
    assign hidx_next   = r_hidx + 1'b1;
    assign tail_sum    = r_tail + {1'b0, r_req};
    assign live_hit    = (live_q.addr == r_baddr);
    assign hole_fit    = (hole_q.size >= r_req);
    assign live_full   = (r_live_cnt == LIVE_FULL);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_in_data.mode)
                        MODE_ALLOC:  n_state = S_ALLOC_START;
                        MODE_FREE:   n_state = S_FREE_RD;
                        MODE_RESIZE: n_state = S_FREE_RD;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_FREE_RD: begin
                n_state = (r_lidx == r_live_cnt) ? S_DONE : S_FREE_CMP;
            end
            S_FREE_CMP: begin
                if (!live_hit) begin
                    n_state = S_FREE_RD;
                end else if (r_live_cnt == LCW'(1)) begin
                    n_state = (r_mode == MODE_FREE) ? S_DONE : S_ALLOC_START;
                end else if (r_hole_cnt == HOLE_FULL) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_HOLE_WR;
                end
            end
            S_HOLE_WR: n_state = S_LSH_RD;
            S_LSH_RD: begin
                if (lidx_next == r_live_cnt) begin
                    n_state = (r_mode == MODE_FREE) ? S_DONE : S_ALLOC_START;
                end else begin
                    n_state = S_LSH_WR;
                end
            end
            S_LSH_WR: n_state = S_LSH_RD;
            S_ALLOC_START: begin
                n_state = (r_req == '0) ? S_DONE : S_HOLE_RD;
            end
            S_HOLE_RD: begin
                if (r_hidx != r_hole_cnt) begin
                    n_state = S_HOLE_CMP;
                end else if (tail_sum >= r_limit || live_full) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_LIVE_WR;
                end
            end
            S_HOLE_CMP: begin
                if (!hole_fit) begin
                    n_state = S_HOLE_RD;
                end else if (live_full) begin
                    n_state = S_DONE;
                end else if (hole_q.size == r_req) begin
                    n_state = S_HSH_RD;
                end else begin
                    n_state = S_LIVE_WR;
                end
            end
            S_HSH_RD: begin
                n_state = (hidx_next == r_hole_cnt) ? S_LIVE_WR : S_HSH_WR;
            end
            S_HSH_WR:  n_state = S_HSH_RD;
            S_LIVE_WR: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory port controls
    always_comb begin
        live_we    = 1'b0;
        hole_we    = 1'b0;
        live_waddr = r_lidx[LW-1:0];
        live_wdata = live_q;
        live_raddr = r_lidx[LW-1:0];
        hole_waddr = r_hidx[HW-1:0];
        hole_wdata = hole_q;
        hole_raddr = r_hidx[HW-1:0];
        case (r_state)
            S_HOLE_WR: begin
                hole_we    = 1'b1;
                hole_waddr = r_hole_cnt[HW-1:0];
                hole_wdata = '{addr: r_baddr, size: r_bytes};
            end
            S_LSH_RD: live_raddr = lidx_next[LW-1:0];
            S_LSH_WR: live_we    = 1'b1;
            S_HOLE_CMP: begin
                // carve from the front of a hole that stays non-empty
                hole_we    = hole_fit && !live_full && (hole_q.size != r_req);
                hole_wdata = '{addr: hole_q.addr + r_req, size: hole_q.size - r_req};
            end
            S_HSH_RD: hole_raddr = hidx_next[HW-1:0];
            S_HSH_WR: hole_we    = 1'b1;
            S_LIVE_WR: begin
                live_we    = 1'b1;
                live_waddr = r_live_cnt[LW-1:0];
                live_wdata = '{addr: r_hit, size: r_req};
            end
            default: begin
                live_we = 1'b0;
            end
        endcase
    end

    // datapath and allocator state updates
    always_comb begin
        n_mode      = r_mode;
        n_req       = r_req;
        n_baddr     = r_baddr;
        n_bytes     = r_bytes;
        n_ga        = r_ga;
        n_st        = r_st;
        n_hit       = r_hit;
        n_lidx      = r_lidx;
        n_hidx      = r_hidx;
        n_limit     = r_limit;
        n_tail      = r_tail;
        n_live_cnt  = r_live_cnt;
        n_hole_cnt  = r_hole_cnt;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (i_cfg_valid) begin
            n_limit = i_cfg_data[LIMIT_BITS-1] ? LIMIT_MAX : i_cfg_data;
        end
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_mode  = i_in_data.mode;
                    n_req   = i_in_data.request_size;
                    n_baddr = i_in_data.block_address;
                    n_bytes = '0;
                    n_st    = ST_OK;
                    n_ga    = (i_in_data.mode == MODE_FREE) ? i_in_data.block_address : '0;
                    n_lidx  = '0;
                end
            end
            S_FREE_RD: begin
                if (r_lidx == r_live_cnt) begin
                    n_st = ST_NOT_ALLOC;
                end
            end
            S_FREE_CMP: begin
                if (!live_hit) begin
                    n_lidx = lidx_next;
                end else if (r_live_cnt == LCW'(1)) begin
                    n_bytes    = live_q.size;
                    n_tail     = '0;
                    n_live_cnt = '0;
                    n_hole_cnt = '0;
                    n_last     = '0;
                end else if (r_hole_cnt == HOLE_FULL) begin
                    n_st = ST_TABLE_FULL;
                end else begin
                    n_bytes = live_q.size;
                end
            end
            S_HOLE_WR: n_hole_cnt = r_hole_cnt + 1'b1;
            S_LSH_RD: begin
                if (lidx_next == r_live_cnt) begin
                    n_live_cnt = r_live_cnt - 1'b1;
                end
            end
            S_LSH_WR: n_lidx = lidx_next;
            S_ALLOC_START: begin
                n_hidx = '0;
                if (r_req == '0) begin
                    n_ga = r_last;
                end
            end
            S_HOLE_RD: begin
                if (r_hidx == r_hole_cnt) begin
                    if (tail_sum >= r_limit) begin
                        n_st = ST_ARENA_FULL;
                    end else if (live_full) begin
                        n_st = ST_TABLE_FULL;
                    end else begin
                        n_hit  = r_tail[ADDR_BITS-1:0];
                        n_tail = tail_sum;
                    end
                end
            end
            S_HOLE_CMP: begin
                if (!hole_fit) begin
                    n_hidx = hidx_next;
                end else if (live_full) begin
                    n_st = ST_TABLE_FULL;
                end else begin
                    n_hit = hole_q.addr;
                end
            end
            S_HSH_RD: begin
                if (hidx_next == r_hole_cnt) begin
                    n_hole_cnt = r_hole_cnt - 1'b1;
                end
            end
            S_HSH_WR: n_hidx = hidx_next;
            S_LIVE_WR: begin
                n_live_cnt = r_live_cnt + 1'b1;
                n_last     = r_hit;
                n_ga       = r_hit;
                if (r_mode == MODE_ALLOC) begin
                    n_bytes = r_req;
                end
            end
            S_DONE: begin
                // final transfer into the output register
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{granted_address: r_ga, block_bytes: r_bytes, status: r_st};
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_MAX;
            r_tail      <= '0;
            r_live_cnt  <= '0;
            r_hole_cnt  <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_limit     <= n_limit;
            r_tail      <= n_tail;
            r_live_cnt  <= n_live_cnt;
            r_hole_cnt  <= n_hole_cnt;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_req   <= n_req;
        r_baddr <= n_baddr;
        r_bytes <= n_bytes;
        r_ga    <= n_ga;
        r_st    <= n_st;
        r_hit   <= n_hit;
        r_lidx  <= n_lidx;
        r_hidx  <= n_hidx;
        r_out   <= n_out;
    end

endmodule

// File: hdl/ffba_span_ram.sv
// ffba_span_ram: single write port, single registered read port span memory
// depends on ffba_pkg for the t_span entry type
`timescale 1ns / 1ps

module ffba_span_ram #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  ffba_pkg::t_span            i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output ffba_pkg::t_span            o_rdata
);
    import ffba_pkg::*;

    t_span r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: bench/first_fit_block_allocator_tb.sv
// first_fit_block_allocator_tb: self-checking bench for the first-fit allocator
// depends on ffba_pkg and the first_fit_block_allocator rtl; directed and random
// requests are checked against an in-bench allocator model, under random stalls
`timescale 1ns / 1ps

module first_fit_block_allocator_tb;
    import ffba_pkg::*;

    localparam int LIVE_SLOTS = 256;
    localparam int HOLE_SLOTS = 64;
    localparam int DRAIN_CYCLES = 4 * LIVE_SLOTS + 4 * HOLE_SLOTS + 40;
    localparam logic [LIMIT_BITS-1:0] LIMIT_FIELD_MAX = 25'h1ff_ffff;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out_data;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [LIMIT_BITS-1:0] i_cfg_data = '0;

    first_fit_block_allocator #(
        .LIVE_SLOTS(LIVE_SLOTS),
        .HOLE_SLOTS(HOLE_SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data(o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    // clock
    always #4 i_clk = ~i_clk;

    // allocator model state
    logic [LIMIT_BITS-1:0] arena_size;
    logic [LIMIT_BITS-1:0] tail;
    int live_n;
    int hole_n;
    logic [ADDR_BITS-1:0] last_addr;
    t_span live_blocks[LIVE_SLOTS];
    t_span holes[HOLE_SLOTS];

    t_in request_queue[$];
    t_out grant_queue[$];
    int errors = 0;
    int cycle = 0;
    int results_seen = 0;
    int requests_sent = 0;

    task automatic clear_arena();
        tail = '0;
        live_n = 0;
        hole_n = 0;
        last_addr = '0;
    endtask

    // first fit from the hole list, else bump the tail
    task automatic model_alloc(input logic [ADDR_BITS-1:0] sz, output logic [1:0] st,
                               output logic [ADDR_BITS-1:0] addr);
        logic [ADDR_BITS-1:0] a;
        logic [LIMIT_BITS:0] want;
        int hit;
        hit = -1;
        addr = '0;
        st = ST_OK;
        if (sz == 0) begin
            addr = last_addr;
            return;
        end
        for (int i = 0; i < hole_n; i++) begin
            if (hit < 0 && holes[i].size >= sz) hit = i;
        end
        if (hit >= 0) begin
            if (live_n >= LIVE_SLOTS) begin
                st = ST_TABLE_FULL;
                return;
            end
            a = holes[hit].addr;
            holes[hit].addr = a + sz;
            holes[hit].size = holes[hit].size - sz;
            if (holes[hit].size == 0) begin
                for (int i = hit; i < hole_n - 1; i++) holes[i] = holes[i + 1];
                hole_n--;
            end
            live_blocks[live_n] = '{addr: a, size: sz};
            live_n++;
            last_addr = a;
            addr = a;
            return;
        end
        want = {1'b0, tail} + sz;
        if (want >= {1'b0, arena_size}) begin
            st = ST_ARENA_FULL;
            return;
        end
        if (live_n >= LIVE_SLOTS) begin
            st = ST_TABLE_FULL;
            return;
        end
        live_blocks[live_n] = '{addr: tail[ADDR_BITS-1:0], size: sz};
        live_n++;
        last_addr = tail[ADDR_BITS-1:0];
        addr = last_addr;
        tail = want[LIMIT_BITS-1:0];
    endtask

    // release the earliest live block at an offset
    task automatic model_free(input logic [ADDR_BITS-1:0] addr, output logic [1:0] st,
                              output logic [ADDR_BITS-1:0] bytes);
        int hit;
        hit = -1;
        bytes = '0;
        st = ST_NOT_ALLOC;
        for (int i = 0; i < live_n; i++) begin
            if (hit < 0 && live_blocks[i].addr == addr) hit = i;
        end
        if (hit < 0) return;
        if (live_n == 1) begin
            bytes = live_blocks[hit].size;
            clear_arena();
            st = ST_OK;
            return;
        end
        if (hole_n >= HOLE_SLOTS) begin
            st = ST_TABLE_FULL;
            return;
        end
        bytes = live_blocks[hit].size;
        holes[hole_n] = live_blocks[hit];
        hole_n++;
        for (int i = hit; i < live_n - 1; i++) live_blocks[i] = live_blocks[i + 1];
        live_n--;
        st = ST_OK;
    endtask

    // predict one request and queue it with its expected grant
    task automatic queue_request(input logic [1:0] mode, input logic [ADDR_BITS-1:0] sz,
                                 input logic [ADDR_BITS-1:0] addr);
        t_out res;
        logic [ADDR_BITS-1:0] got;
        res = '0;
        got = '0;
        case (mode)
            MODE_ALLOC: begin
                model_alloc(sz, res.status, got);
                if (res.status == ST_OK) begin
                    res.granted_address = got;
                    res.block_bytes = sz;
                end
            end
            MODE_FREE: begin
                model_free(addr, res.status, res.block_bytes);
                res.granted_address = addr;
            end
            MODE_RESIZE: begin
                model_free(addr, res.status, res.block_bytes);
                if (res.status == ST_OK) begin
                    model_alloc(sz, res.status, got);
                    if (res.status == ST_OK) res.granted_address = got;
                end
            end
            default: ;
        endcase
        request_queue.push_back('{mode: mode, request_size: sz, block_address: addr});
        grant_queue.push_back(res);
    endtask

    function automatic logic [ADDR_BITS-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 72) return ADDR_BITS'($urandom_range(64, 1));
        if (r < 90) return ADDR_BITS'($urandom_range(4096));
        return ADDR_BITS'($urandom);
    endfunction

    function automatic logic [ADDR_BITS-1:0] pick_address();
        int r;
        r = $urandom_range(99);
        if (r < 80 && live_n > 0) return live_blocks[$urandom_range(live_n - 1)].addr;
        if (r < 90 && hole_n > 0) return holes[$urandom_range(hole_n - 1)].addr;
        return ADDR_BITS'($urandom);
    endfunction

    // mostly well-formed alloc/free/resize traffic, some noise
    task automatic queue_random(input int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 45) queue_request(MODE_ALLOC, pick_size(), ADDR_BITS'($urandom));
            else if (r < 75) queue_request(MODE_FREE, ADDR_BITS'($urandom), pick_address());
            else if (r < 95) queue_request(MODE_RESIZE, pick_size(), pick_address());
            else queue_request(2'd3, ADDR_BITS'($urandom), ADDR_BITS'($urandom));
        end
    endtask

    // wait for every queued request to complete and the block to go quiet
    task automatic drain();
        while (request_queue.size() != 0 || i_in_valid || grant_queue.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // arena limit write, block idle
    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        arena_size = (value > LIMIT_MAX) ? LIMIT_MAX : value;
    endtask

    // request driver
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) requests_sent <= requests_sent + 1;
            if (request_queue.size() != 0 &&
                ((cycle > 60000 && cycle < 90000) || $urandom_range(99) >= 12)) begin
                i_in_valid <= 1'b1;
                i_in_data <= request_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stall
    always @(posedge i_clk) begin
        t_out exp_res;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen <= results_seen + 1;
                if (grant_queue.size() == 0) begin
                    $error("result transfer with nothing expected: %h", o_out_data);
                    errors++;
                end else begin
                    exp_res = grant_queue.pop_front();
                    if (o_out_data.granted_address !== exp_res.granted_address) begin
                        $error("granted_address expected %h actual %h",
                               exp_res.granted_address, o_out_data.granted_address);
                        errors++;
                    end
                    if (o_out_data.block_bytes !== exp_res.block_bytes) begin
                        $error("block_bytes expected %h actual %h",
                               exp_res.block_bytes, o_out_data.block_bytes);
                        errors++;
                    end
                    if (o_out_data.status !== exp_res.status) begin
                        $error("status expected %0d actual %0d",
                               exp_res.status, o_out_data.status);
                        errors++;
                    end
                end
            end
            // long hold-off so the input side backs up
            if (cycle >= 20000 && cycle < 23000) i_out_stall <= 1'b1;
            else if (cycle > 60000 && cycle < 90000) i_out_stall <= 1'b0;
            else i_out_stall <= ($urandom_range(99) < 12);
        end
    end

    // run timeout
    initial begin
        #100ms;
        $display("Some tests failed");
        $finish;
    end

    // stimulus and end of run
    initial begin
        logic [ADDR_BITS-1:0] a;
        logic [ADDR_BITS-1:0] b;
        clear_arena();
        arena_size = LIMIT_MAX;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero size, offset zero, unknown offsets, carving, resize cases
        queue_request(MODE_ALLOC, 24'd0, 24'd0);
        queue_request(MODE_ALLOC, 24'd1, 24'hffffff);
        queue_request(MODE_ALLOC, 24'd16, 24'd0);
        queue_request(MODE_ALLOC, 24'hffffff, 24'd0);
        queue_request(MODE_ALLOC, 24'd32, 24'd0);
        queue_request(MODE_FREE, 24'd0, 24'd0);
        queue_request(MODE_FREE, 24'hffffff, 24'h0abcde);
        queue_request(MODE_RESIZE, 24'd8, 24'd1);
        queue_request(MODE_ALLOC, 24'd1, 24'd0);
        queue_request(MODE_RESIZE, 24'd0, 24'd17);
        queue_request(MODE_RESIZE, 24'd4, 24'hffffff);
        queue_request(2'd3, 24'hffffff, 24'hffffff);
        queue_request(MODE_RESIZE, 24'hffffff, 24'd0);
        queue_request(MODE_ALLOC, 24'd0, 24'd0);
        while (live_n > 0) queue_request(MODE_FREE, 24'd0, live_blocks[0].addr);
        queue_request(MODE_ALLOC, 24'hffffff, 24'd0);
        queue_request(MODE_FREE, 24'd0, 24'd0);
        drain();

        // one-byte arena: nothing fits
        write_limit(25'd1);
        queue_random(30);
        drain();

        // field maximum; fill the live table, then the hole list
        write_limit(LIMIT_FIELD_MAX);
        for (int k = 0; k < LIVE_SLOTS + 3; k++)
            queue_request(MODE_ALLOC, ADDR_BITS'($urandom_range(8, 1)), 24'd0);
        for (int k = 0; k < HOLE_SLOTS + 3; k++)
            queue_request(MODE_FREE, 24'd0, live_blocks[k % 4].addr);
        queue_request(MODE_ALLOC, 24'd3, 24'd0);
        queue_random(200);
        drain();

        // tight arena
        write_limit(25'd300);
        queue_random(250);
        drain();

        write_limit(LIMIT_BITS'($urandom_range(20000, 2000)));
        queue_random(300);
        drain();

        write_limit(LIMIT_MAX);
        queue_random(200);
        drain();

        $display("%0d requests and %0d results checked over six arena limits,",
                 requests_sent, results_seen);
        $display("including full arena, full live table, full hole list and resizes");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: first_fit_block_allocator.f
hdl/ffba_pkg.sv
hdl/ffba_span_ram.sv
hdl/first_fit_block_allocator.sv
bench/first_fit_block_allocator_tb.sv
